FILE: hw/rtl/ofcc_pkg.sv
// Shared types and constants for the fragment coverage check.
`timescale 1ns / 1ps

package ofcc_pkg;

  localparam int MAX_FRAGMENTS = 256;
  localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
  localparam int RX_W = 16 + CNT_W;
  localparam int LENGTH_SLACK = 1500;
  localparam int TREE_FAN_W = 4;
  localparam int TREE_FAN = 1 << TREE_FAN_W;

  function automatic int tree_levels(int n);
    int lv;
    int span;
    lv = 1;
    span = TREE_FAN;
    while (span < n) begin
      span = span * TREE_FAN;
      lv = lv + 1;
    end
    return lv;
  endfunction

  localparam int TREE_LEVELS = tree_levels(MAX_FRAGMENTS);
  localparam int TREE_PAD = 1 << (TREE_FAN_W * TREE_LEVELS);
  localparam int PHASE_LAST = TREE_LEVELS + 2;
  localparam int PHASE_W = $clog2(PHASE_LAST + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESSING_MODE = 2'd1;

  localparam logic MODE_OFFSET = 1'b0;
  localparam logic MODE_BLOCK = 1'b1;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] pos;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    logic        insert;
    logic [31:0] key;
    logic [31:0] pos;
    logic [15:0] len;
  } ins_t;

endpackage

FILE: hw/rtl/ofcc_cell.sv
// One cell of the sorted fragment chain: holds an entry, inserts or shifts, checks its link.
`timescale 1ns / 1ps

module ofcc_cell (
  input  logic                  clk,
  input  ofcc_pkg::ins_t        ins,
  input  logic                  occ,
  input  logic                  next_occ,
  input  logic                  prev_gt,
  input  ofcc_pkg::entry_t      prev_entry,
  input  logic [32:0]           prev_tail,
  input  logic [31:0]           total_len,
  output ofcc_pkg::entry_t      entry,
  output logic                  gt,
  output logic [32:0]           tail,
  output logic                  ok
);

  logic link;
  logic fin;

  assign gt = !occ || (entry.key > ins.key);

  always_ff @(posedge clk) begin
    if (ins.insert && gt) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else begin
        entry.key <= ins.key;
        entry.pos <= ins.pos;
        entry.len <= ins.len;
      end
    end
  end

  assign tail = {1'b0, entry.pos} + 33'(entry.len);
  assign link = ({1'b0, entry.pos} == prev_tail);
  assign fin  = (tail == {1'b0, total_len});
  assign ok   = !occ || (link && (next_occ || fin));

endmodule

FILE: hw/rtl/ofcc_reduce.sv
// Registered AND tree over the per-cell link checks.
`timescale 1ns / 1ps

module ofcc_reduce (
  input  logic                               clk,
  input  logic [ofcc_pkg::MAX_FRAGMENTS-1:0] ok,
  output logic                               all_ok
);

  logic [ofcc_pkg::TREE_PAD-1:0] leaf;
  logic [ofcc_pkg::TREE_PAD-1:0] lvl [0:ofcc_pkg::TREE_LEVELS];

  for (genvar b = 0; b < ofcc_pkg::TREE_PAD; b++) begin : g_leaf
    if (b < ofcc_pkg::MAX_FRAGMENTS) begin : g_used
      assign leaf[b] = ok[b];
    end else begin : g_pad
      assign leaf[b] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    lvl[0] <= leaf;
    for (int lv = 1; lv <= ofcc_pkg::TREE_LEVELS; lv++) begin
      for (int g = 0; g < ofcc_pkg::TREE_PAD; g++) begin
        if (g < (ofcc_pkg::TREE_PAD >> (ofcc_pkg::TREE_FAN_W * lv))) begin
          lvl[lv][g] <= &lvl[lv-1][g*ofcc_pkg::TREE_FAN +: ofcc_pkg::TREE_FAN];
        end else begin
          lvl[lv][g] <= 1'b1;
        end
      end
    end
  end

  assign all_ok = lvl[ofcc_pkg::TREE_LEVELS][0];

endmodule

FILE: hw/rtl/object_fragment_coverage_check.sv
// Top level: fragment store as a sorted cell chain, coverage reduction and command handshake.
// A word accepted while idle raises busy and passes through insert, AND tree and result phases;
//   the result strobe is registered after the last phase, and no new word is accepted while busy.
// Reset: synchronous, clears fragment count, byte count, registers and handshake;
//   stored entries are not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module object_fragment_coverage_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           new_object,
  input  logic [31:0]                    frag_offset,
  input  logic [15:0]                    block_number,
  input  logic [31:0]                    symbol_index,
  input  logic [15:0]                    fragment_len,
  output logic                           done,
  output logic                           complete,
  output logic                           dropped,
  output logic [8:0]                     fragment_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ofcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int N = ofcc_pkg::MAX_FRAGMENTS;

  logic [31:0]                total_len;
  logic                       addressing_mode;
  logic [ofcc_pkg::CNT_W-1:0] count;
  logic [ofcc_pkg::RX_W-1:0]  rx_bytes;
  logic [ofcc_pkg::PHASE_W-1:0] phase;
  logic                       drop_pend;

  logic                       accept;
  logic [ofcc_pkg::CNT_W-1:0] eff_count;
  logic [ofcc_pkg::CNT_W-1:0] occ_count;
  logic                       full;
  ofcc_pkg::ins_t             ins;
  logic [31:0]                threshold;
  logic                       early_ok;
  logic                       all_ok;

  ofcc_pkg::entry_t cell_entry [N];
  logic [N-1:0]     cell_gt;
  logic [32:0]      cell_tail [N];
  logic [N-1:0]     cell_ok;
  logic [N-1:0]     occ;

  assign cfg_ready = 1'b1;
  assign busy      = (phase != ofcc_pkg::PHASE_W'(0));
  assign accept    = start && !busy;
  assign eff_count = new_object ? '0 : count;
  assign full      = (eff_count >= ofcc_pkg::CNT_W'(N));
  assign occ_count = accept ? eff_count : count;

  always_comb begin
    ins.insert = accept && !full;
    if (addressing_mode == ofcc_pkg::MODE_BLOCK) begin
      ins.key = {16'd0, block_number};
      ins.pos = symbol_index;
    end else begin
      ins.key = frag_offset;
      ins.pos = frag_offset;
    end
    ins.len = fragment_len;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = (ofcc_pkg::CNT_W'(i) < occ_count);
    if (i == 0) begin : g_head
      ofcc_cell u_cell (
        .clk           (clk),
        .ins           (ins),
        .occ           (occ[i]),
        .next_occ      (occ[i+1]),
        .prev_gt       (1'b0),
        .prev_entry    ('0),
        .prev_tail     (33'd0),
        .total_len     (total_len),
        .entry         (cell_entry[i]),
        .gt            (cell_gt[i]),
        .tail          (cell_tail[i]),
        .ok            (cell_ok[i])
      );
    end else if (i == N - 1) begin : g_last
      ofcc_cell u_cell (
        .clk           (clk),
        .ins           (ins),
        .occ           (occ[i]),
        .next_occ      (1'b0),
        .prev_gt       (cell_gt[i-1]),
        .prev_entry    (cell_entry[i-1]),
        .prev_tail     (cell_tail[i-1]),
        .total_len     (total_len),
        .entry         (cell_entry[i]),
        .gt            (cell_gt[i]),
        .tail          (cell_tail[i]),
        .ok            (cell_ok[i])
      );
    end else begin : g_mid
      ofcc_cell u_cell (
        .clk           (clk),
        .ins           (ins),
        .occ           (occ[i]),
        .next_occ      (occ[i+1]),
        .prev_gt       (cell_gt[i-1]),
        .prev_entry    (cell_entry[i-1]),
        .prev_tail     (cell_tail[i-1]),
        .total_len     (total_len),
        .entry         (cell_entry[i]),
        .gt            (cell_gt[i]),
        .tail          (cell_tail[i]),
        .ok            (cell_ok[i])
      );
    end
  end

  ofcc_reduce u_reduce (
    .clk    (clk),
    .ok     (cell_ok),
    .all_ok (all_ok)
  );

  // byte-count early out
  assign threshold = (total_len > 32'(ofcc_pkg::LENGTH_SLACK + 1)) ?
                     (total_len - 32'(ofcc_pkg::LENGTH_SLACK)) : 32'd1;
  assign early_ok  = (total_len != 32'd0) && (32'(rx_bytes) >= threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_len       <= '0;
      addressing_mode <= ofcc_pkg::MODE_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ofcc_pkg::REG_OBJECT_LENGTH:   total_len <= cfg_data;
        ofcc_pkg::REG_ADDRESSING_MODE: addressing_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rx_bytes <= '0;
      phase    <= '0;
      done     <= 1'b0;
    end else begin
      done <= (phase == ofcc_pkg::PHASE_W'(ofcc_pkg::PHASE_LAST));
      if (accept) begin
        count     <= full ? eff_count : eff_count + ofcc_pkg::CNT_W'(1);
        rx_bytes  <= (new_object ? '0 : rx_bytes) +
                     (full ? '0 : ofcc_pkg::RX_W'(fragment_len));
        drop_pend <= full;
        phase     <= ofcc_pkg::PHASE_W'(1);
      end else if (phase == ofcc_pkg::PHASE_W'(ofcc_pkg::PHASE_LAST)) begin
        phase          <= '0;
        complete       <= all_ok && early_ok && (count != '0);
        dropped        <= drop_pend;
        fragment_count <= 9'(count);
      end else if (busy) begin
        phase <= phase + ofcc_pkg::PHASE_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (phase == ofcc_pkg::PHASE_W'(ofcc_pkg::PHASE_LAST)) |=> done)
    else $error("result strobe missing after final phase");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ofcc_pkg::CNT_W'(N))
    else $error("fragment count beyond store depth");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> (count == ofcc_pkg::CNT_W'(N)))
    else $error("word dropped with store not full");
  a_complete_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && complete) |-> (count != '0 && total_len != 32'd0))
    else $error("complete reported on empty store or unknown length");
`endif

endmodule

FILE: verif/object_fragment_coverage_check_test.sv
// Testbench for the fragment coverage check: directed and random fragment words against a scoreboard.
`timescale 1ns / 1ps

module object_fragment_coverage_check_test;

  import ofcc_pkg::*;

  typedef struct packed {
    logic       complete;
    logic       dropped;
    logic [8:0] count;
  } coverage_report_t;

  class coverage_scoreboard;
    logic [31:0]       keys [MAX_FRAGMENTS];
    logic [31:0]       posns [MAX_FRAGMENTS];
    logic [15:0]       lens [MAX_FRAGMENTS];
    int unsigned       stored;
    longint unsigned   rx_bytes;
    logic [31:0]       obj_len;
    logic              mode;
    coverage_report_t  expected_reports[$];
    int unsigned       mismatches;

    function new();
      stored = 0;
      rx_bytes = 0;
      obj_len = '0;
      mode = MODE_OFFSET;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_OBJECT_LENGTH) obj_len = data;
      else if (idx == REG_ADDRESSING_MODE) mode = data[0];
    endfunction

    function bit covered();
      longint unsigned thr;
      longint unsigned run_end;
      if (obj_len == 0) return 1'b0;
      thr = (obj_len > LENGTH_SLACK + 1) ? longint'(obj_len) - LENGTH_SLACK : 1;
      if (rx_bytes < thr) return 1'b0;
      run_end = 0;
      for (int i = 0; i < stored; i++) begin
        if (longint'(posns[i]) != run_end) return 1'b0;
        run_end += lens[i];
      end
      return run_end == longint'(obj_len);
    endfunction

    function void note_fragment(logic nobj, logic [31:0] so, logic [15:0] bn,
                                logic [31:0] si, logic [15:0] flen);
      coverage_report_t rep;
      logic [31:0] key;
      logic [31:0] pos;
      int unsigned slot;
      if (nobj) begin
        stored = 0;
        rx_bytes = 0;
      end
      rep.dropped = 1'b0;
      if (stored >= MAX_FRAGMENTS) begin
        rep.dropped = 1'b1;
      end else begin
        key = (mode == MODE_BLOCK) ? {16'h0, bn} : so;
        pos = (mode == MODE_BLOCK) ? si : so;
        slot = 0;
        while (slot < stored && keys[slot] <= key) slot++;
        for (int j = stored; j > slot; j--) begin
          keys[j] = keys[j-1];
          posns[j] = posns[j-1];
          lens[j] = lens[j-1];
        end
        keys[slot] = key;
        posns[slot] = pos;
        lens[slot] = flen;
        stored++;
        rx_bytes += flen;
      end
      rep.complete = covered();
      rep.count = stored[8:0];
      expected_reports.push_back(rep);
    endfunction

    function void check_result(logic c, logic d, logic [8:0] cnt);
      coverage_report_t rep;
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected result: complete %0d dropped %0d count %0d",
                 $time, c, d, cnt);
        mismatches++;
        return;
      end
      rep = expected_reports.pop_front();
      if (c !== rep.complete) begin
        $display("%0t complete: expected %0d, actual %0d", $time, rep.complete, c);
        mismatches++;
      end
      if (d !== rep.dropped) begin
        $display("%0t dropped: expected %0d, actual %0d", $time, rep.dropped, d);
        mismatches++;
      end
      if (cnt !== rep.count) begin
        $display("%0t fragment_count: expected %0d, actual %0d", $time, rep.count, cnt);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 new_object = 1'b0;
  logic [31:0]          frag_offset = '0;
  logic [15:0]          block_number = '0;
  logic [31:0]          symbol_index = '0;
  logic [15:0]          fragment_len = '0;
  logic                 done;
  logic                 complete;
  logic                 dropped;
  logic [8:0]           fragment_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  coverage_scoreboard sb = new();
  logic        cur_mode = MODE_OFFSET;
  int unsigned words_sent = 0;
  int unsigned phase = 0;

  object_fragment_coverage_check DUT (
    .clk, .rst, .start, .busy, .new_object, .frag_offset, .block_number,
    .symbol_index, .fragment_len, .done, .complete, .dropped, .fragment_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("object_fragment_coverage_check: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(complete, dropped, fragment_count);
  end

  task automatic send_fragment(input logic nobj, input logic [31:0] so, input logic [15:0] bn,
                               input logic [31:0] si, input logic [15:0] flen);
    // no idling over a long stretch of words
    if (!(words_sent >= 300 && words_sent < 550) && $urandom_range(99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    new_object <= nobj;
    frag_offset <= so;
    block_number <= bn;
    symbol_index <= si;
    fragment_len <= flen;
    do @(posedge clk); while (busy);
    sb.note_fragment(nobj, so, bn, si, flen);
    words_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TREE_LEVELS + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [31:0] olen, input logic m);
    settle();
    write_reg(REG_OBJECT_LENGTH, olen);
    write_reg(REG_ADDRESSING_MODE, {31'h0, m});
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  task automatic send_pieces(input logic [31:0] pos_q[$], input logic [15:0] len_q[$],
                             input logic [15:0] key_q[$], input bit mix, input bit fresh,
                             input bit strays);
    int order[$];
    int j;
    int t;
    int k;
    logic nobj;
    for (int i = 0; i < pos_q.size(); i++) order.push_back(i);
    if (mix) begin
      for (int i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int i = 0; i < order.size(); i++) begin
      k = order[i];
      nobj = (i == 0) ? fresh : (strays && $urandom_range(39) == 0);
      if (cur_mode == MODE_BLOCK) send_fragment(nobj, $urandom, key_q[k], pos_q[k], len_q[k]);
      else send_fragment(nobj, pos_q[k], 16'($urandom), $urandom, len_q[k]);
    end
  endtask

  // one object split into fragments of the configured length, sometimes flawed
  task automatic send_object(input logic [31:0] olen);
    logic [31:0] pos_q[$];
    logic [15:0] len_q[$];
    logic [15:0] key_q[$];
    longint unsigned remaining;
    longint unsigned cut;
    longint unsigned maxpiece;
    longint unsigned p;
    logic [15:0] k;
    int idx;
    remaining = olen;
    p = 0;
    k = 16'($urandom_range(0, 65535 - 200));
    maxpiece = longint'(olen) / $urandom_range(1, 8) + 1;
    if (maxpiece > 65535) maxpiece = 65535;
    while (remaining != 0 && pos_q.size() < 12) begin
      cut = $urandom_range(1, 32'(maxpiece));
      if (cut > remaining) cut = remaining;
      pos_q.push_back(32'(p));
      len_q.push_back(16'(cut));
      key_q.push_back(k);
      k = k + (($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
      p += cut;
      remaining -= cut;
      if ($urandom_range(19) == 0) begin
        pos_q.push_back(32'(p));
        len_q.push_back(16'h0);
        key_q.push_back(k);
        k = k + 16'd1;
      end
    end
    if (pos_q.size() == 0) begin
      pos_q.push_back(32'h0);
      len_q.push_back(16'($urandom_range(0, 100)));
      key_q.push_back(k);
    end
    idx = $urandom_range(0, pos_q.size() - 1);
    case ($urandom_range(0, 9))
      6: begin
        pos_q.delete(idx);
        len_q.delete(idx);
        key_q.delete(idx);
      end
      7: begin
        pos_q.push_back(pos_q[idx]);
        len_q.push_back(len_q[idx]);
        key_q.push_back(key_q[idx]);
      end
      8: pos_q[idx] = ($urandom_range(1) != 0) ? pos_q[idx] + 32'd1 : pos_q[idx] - 32'd1;
      9: begin
        pos_q.push_back(32'(p));
        len_q.push_back(16'($urandom_range(1, 100)));
        key_q.push_back(k + 16'd1);
      end
      default: ;
    endcase
    if (pos_q.size() != 0)
      send_pieces(pos_q, len_q, key_q, $urandom_range(1) != 0, $urandom_range(19) != 0, 1'b1);
  endtask

  // fills the store to capacity, then offers a few more words that must be dropped
  task automatic fill_store(input logic m);
    logic [31:0] pos_q[$];
    logic [15:0] len_q[$];
    logic [15:0] key_q[$];
    logic [15:0] piece;
    piece = 16'($urandom_range(1, 300));
    configure(32'(MAX_FRAGMENTS * piece), m);
    for (int i = 0; i < MAX_FRAGMENTS; i++) begin
      pos_q.push_back(32'(i * piece));
      len_q.push_back(piece);
      key_q.push_back(16'(i));
    end
    send_pieces(pos_q, len_q, key_q, 1'b1, 1'b1, 1'b0);
    repeat (3) send_fragment(1'b0, $urandom, 16'($urandom), $urandom, 16'($urandom));
  endtask

  initial begin
    logic [31:0] olen;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // length still unknown after reset
    send_fragment(1'b1, 32'd0, 16'd0, 32'd0, 16'd100);
    configure(32'd300, MODE_OFFSET);
    send_fragment(1'b1, 32'd0, 16'($urandom), $urandom, 16'd100);
    send_fragment(1'b0, 32'd200, 16'($urandom), $urandom, 16'd100);
    send_fragment(1'b0, 32'd100, 16'($urandom), $urandom, 16'd100);
    send_fragment(1'b0, 32'd100, 16'($urandom), $urandom, 16'd100);
    send_fragment(1'b1, 32'd0, 16'($urandom), $urandom, 16'd300);
    send_fragment(1'b0, 32'd300, 16'($urandom), $urandom, 16'd0);
    send_fragment(1'b1, 32'd0, 16'($urandom), $urandom, 16'd400);
    send_fragment(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_fragment(1'b0, 32'd0, 16'd0, 32'd0, 16'd0);
    configure(32'd1, MODE_OFFSET);
    send_fragment(1'b1, 32'd0, 16'($urandom), $urandom, 16'd1);
    configure(32'hFFFF_FFFF, MODE_OFFSET);
    send_fragment(1'b1, 32'd0, 16'($urandom), $urandom, 16'hFFFF);
    configure(32'd300, MODE_BLOCK);
    send_fragment(1'b1, $urandom, 16'd2, 32'd200, 16'd100);
    send_fragment(1'b0, $urandom, 16'd0, 32'd0, 16'd100);
    send_fragment(1'b0, $urandom, 16'd1, 32'd100, 16'd100);
    // equal keys stay in arrival order
    send_fragment(1'b1, $urandom, 16'd7, 32'd0, 16'd150);
    send_fragment(1'b0, $urandom, 16'd7, 32'd150, 16'd150);
    send_fragment(1'b1, $urandom, 16'd7, 32'd150, 16'd150);
    send_fragment(1'b0, $urandom, 16'd7, 32'd0, 16'd150);
    send_fragment(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    // mode change with entries still stored
    configure(32'd300, MODE_OFFSET);
    send_fragment(1'b0, 32'd3, 16'd0, 32'd0, 16'd10);

    while (words_sent < 1160) begin
      phase++;
      if (phase == 3 || phase == 9) begin
        fill_store(phase == 9);
      end else begin
        case ($urandom_range(0, 9))
          0: olen = 32'd0;
          1: olen = 32'hFFFF_FFFF;
          2: olen = $urandom_range(1501, 1502);
          3: olen = 32'd1;
          default: begin
            olen = 0;
            repeat ($urandom_range(1, 10)) begin
              case ($urandom_range(2))
                0: olen += $urandom_range(0, 100);
                1: olen += $urandom_range(0, 3000);
                default: olen += $urandom_range(0, 65535);
              endcase
            end
          end
        endcase
        configure(olen, $urandom_range(1) != 0);
        repeat ($urandom_range(3, 8)) begin
          case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 3))
                 send_fragment($urandom_range(3) == 0, $urandom, 16'($urandom), $urandom,
                               16'($urandom));
            1: settle();
            default: send_object(olen);
          endcase
        end
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("object_fragment_coverage_check: match");
    else $display("object_fragment_coverage_check: mismatch");
    $finish;
  end

endmodule
